// File: rtl/ndig_pkg.sv
// ndig_pkg: shared types and constants for the N-d index generator.
// No dependencies.
package ndig_pkg;
  localparam int unsigned NumRegs = 7;
  localparam logic [2:0] REG_DIMS  = 3'd0;
  localparam logic [2:0] REG_EXT0  = 3'd1;
  localparam logic [2:0] REG_EXT1  = 3'd2;
  localparam logic [2:0] REG_EXT2  = 3'd3;
  localparam logic [2:0] REG_EXT3  = 3'd4;
  localparam logic [2:0] REG_AXIS  = 3'd5;
  localparam logic [2:0] REG_FLOAT = 3'd6;
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  typedef struct packed {
    logic        command;
    logic [31:0] start_offset;
    logic [15:0] element_count;
  } in_word_t;

  typedef struct packed {
    logic [31:0] selected_value;
    logic [31:0] coord_0;
    logic [31:0] coord_1;
    logic [31:0] coord_2;
    logic [31:0] coord_3;
    logic        last_of_job;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV_INIT, ST_DIV_RUN, ST_DIV_STORE, ST_DONE
  } state_t;

  typedef struct packed {
    logic load_start;
    logic div_init;
    logic div_run;
    logic div_store;
    logic do_step;
  } cmd_t;

  typedef struct packed {
    logic div_last_bit;
    logic dims_done;
    logic have_elems;
  } stat_t;

  // IEEE single encoding of an unsigned 32-bit value, round to nearest even
  function automatic logic [31:0] to_single(input logic [31:0] v);
    logic [4:0]  p;
    logic [31:0] norm;
    logic [23:0] mant;
    logic [7:0]  expo;
    logic        g, s;
    logic [24:0] rnd;
    p = 5'd0;
    for (int i = 0; i < 32; i++) if (v[i]) p = 5'(i);
    norm = v << (5'd31 - p);
    mant = norm[31:8];
    g = norm[7];
    s = |norm[6:0];
    rnd = {1'b0, mant} + 25'(g & (s | mant[0]));
    expo = 8'd127 + {3'd0, p};
    if (rnd[24]) begin
      expo = expo + 8'd1;
      rnd = rnd >> 1;
    end
    to_single = (v == 32'd0) ? 32'd0 : {1'b0, expo, rnd[22:0]};
  endfunction
endpackage

// File: rtl/ndig_ctrl.sv
// ndig_ctrl: controller FSM for start decomposition and steps.
// Depends on ndig_pkg.
module ndig_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic              in_cmd,
  input  logic              out_free,
  input  ndig_pkg::stat_t   stat,
  output logic              busy,
  output ndig_pkg::cmd_t    cmd
);
  ndig_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ndig_pkg::ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ndig_pkg::ST_IDLE:
        if (in_fire && in_cmd == ndig_pkg::CMD_START) state_nxt = ndig_pkg::ST_DIV_INIT;
      ndig_pkg::ST_DIV_INIT:
        state_nxt = stat.dims_done ? ndig_pkg::ST_IDLE : ndig_pkg::ST_DIV_RUN;
      ndig_pkg::ST_DIV_RUN:
        if (stat.div_last_bit) state_nxt = ndig_pkg::ST_DIV_STORE;
      ndig_pkg::ST_DIV_STORE:
        state_nxt = ndig_pkg::ST_DIV_INIT;
      default: state_nxt = ndig_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = 1'b1;
    case (state_r)
      ndig_pkg::ST_IDLE: begin
        busy = !out_free;
        cmd.load_start = in_fire && in_cmd == ndig_pkg::CMD_START;
        cmd.do_step = in_fire && in_cmd == ndig_pkg::CMD_STEP && stat.have_elems;
      end
      ndig_pkg::ST_DIV_INIT: cmd.div_init = !stat.dims_done;
      ndig_pkg::ST_DIV_RUN: cmd.div_run = 1'b1;
      ndig_pkg::ST_DIV_STORE: cmd.div_store = 1'b1;
      default: cmd = '0;
    endcase
  end
endmodule

// File: rtl/ndig_datapath.sv
// ndig_datapath: config registers, coordinates, bit-serial divider, output register.
// Depends on ndig_pkg.
module ndig_datapath #(
  parameter int unsigned MAX_DIMS = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_fire,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  ndig_pkg::in_word_t  in_word,
  input  ndig_pkg::cmd_t      cmd,
  input  logic                out_ready,
  output ndig_pkg::stat_t     stat,
  output logic                out_free,
  output logic                out_valid,
  output ndig_pkg::out_word_t out_word
);
  localparam int unsigned LIM = (MAX_DIMS < 4) ? MAX_DIMS : 4;

  logic [2:0]  dims_r;
  logic [15:0] ext_r [4];
  logic [1:0]  axis_r;
  logic        flt_r;
  logic [31:0] crd_r [4];
  logic [15:0] rem_r;
  logic [31:0] quo_r;
  logic [15:0] part_r;
  logic [4:0]  bit_r;
  logic [2:0]  dim_r;
  logic        ov_r;
  ndig_pkg::out_word_t ow_r;

  logic [2:0]  n;
  logic [15:0] ee [4];
  logic [1:0]  dsel;
  logic [16:0] trial;
  logic [31:0] enc [4];
  logic [31:0] nc [4];
  logic        carry;

  assign n = (dims_r > 3'(LIM)) ? 3'(LIM) : dims_r;
  always_comb for (int i = 0; i < 4; i++) ee[i] = (ext_r[i] == 16'd0) ? 16'd1 : ext_r[i];
  assign dsel = 2'(dim_r - 3'd1);
  assign trial = {part_r, quo_r[31]};

  assign stat.div_last_bit = (bit_r == 5'd31);
  assign stat.dims_done = (dim_r == 3'd0);
  assign stat.have_elems = (rem_r != 16'd0);
  assign out_free = !ov_r || out_ready;
  assign out_valid = ov_r;
  assign out_word = ow_r;

  always_comb begin
    for (int i = 0; i < 4; i++)
      enc[i] = (3'(i) < n) ? (flt_r ? ndig_pkg::to_single(crd_r[i]) : crd_r[i]) : 32'd0;
    carry = 1'b1;
    for (int d = 3; d >= 0; d--) begin
      nc[d] = crd_r[d];
      if (carry && 3'(d) < n) begin
        nc[d] = crd_r[d] + 32'd1;
        if (d != 0 && nc[d] >= {16'd0, ee[d]}) nc[d] = 32'd0;
        else carry = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r <= 3'd1;
      for (int i = 0; i < 4; i++) ext_r[i] <= 16'd1;
      axis_r <= 2'd0;
      flt_r <= 1'b0;
      for (int i = 0; i < 4; i++) crd_r[i] <= 32'd0;
      rem_r <= 16'd0;
      dim_r <= 3'd0;
      bit_r <= 5'd0;
      ov_r <= 1'b0;
    end else begin
      if (cfg_fire) begin
        case (cfg_index)
          ndig_pkg::REG_DIMS:  dims_r <= cfg_data[2:0];
          ndig_pkg::REG_EXT0:  ext_r[0] <= cfg_data[15:0];
          ndig_pkg::REG_EXT1:  ext_r[1] <= cfg_data[15:0];
          ndig_pkg::REG_EXT2:  ext_r[2] <= cfg_data[15:0];
          ndig_pkg::REG_EXT3:  ext_r[3] <= cfg_data[15:0];
          ndig_pkg::REG_AXIS:  axis_r <= cfg_data[1:0];
          ndig_pkg::REG_FLOAT: flt_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (ov_r && out_ready && !cmd.do_step) ov_r <= 1'b0;
      if (cmd.load_start) begin
        for (int i = 0; i < 4; i++) crd_r[i] <= 32'd0;
        rem_r <= in_word.element_count;
        quo_r <= in_word.start_offset;
        dim_r <= n;
      end
      if (cmd.div_init) begin
        part_r <= 16'd0;
        bit_r <= 5'd0;
      end
      if (cmd.div_run) begin
        // restoring division, one quotient bit per cycle
        if (trial >= {1'b0, ee[dsel]}) begin
          part_r <= 16'(trial - {1'b0, ee[dsel]});
          quo_r <= {quo_r[30:0], 1'b1};
        end else begin
          part_r <= trial[15:0];
          quo_r <= {quo_r[30:0], 1'b0};
        end
        bit_r <= bit_r + 5'd1;
      end
      if (cmd.div_store) begin
        crd_r[dsel] <= {16'd0, part_r};
        dim_r <= dim_r - 3'd1;
      end
      if (cmd.do_step) begin
        ov_r <= 1'b1;
        ow_r.selected_value <= ({1'b0, axis_r} < n) ? enc[axis_r] : 32'd0;
        ow_r.coord_0 <= enc[0];
        ow_r.coord_1 <= enc[1];
        ow_r.coord_2 <= enc[2];
        ow_r.coord_3 <= enc[3];
        ow_r.last_of_job <= (rem_r == 16'd1);
        rem_r <= rem_r - 16'd1;
        for (int i = 0; i < 4; i++) crd_r[i] <= nc[i];
      end
    end
  end
endmodule

// File: rtl/nd_index_generator.sv
// nd_index_generator: mixed-radix N-d index counter, top level.
// Step: one word per cycle while the output is not stalled; the result is registered
// and valid in the next cycle. Start: a bit-serial 32-bit divider per active dimension.
// Reset: synchronous active-low rst_n; registers to defaults, coordinates
// and remaining count to zero. Depends on ndig_pkg, ndig_ctrl, ndig_datapath.
module nd_index_generator #(
  parameter int unsigned MAX_DIMS = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ndig_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ndig_pkg::out_word_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  ndig_pkg::cmd_t  cmd;
  ndig_pkg::stat_t stat;
  logic busy, out_free, in_fire;

  assign in_ready = !busy;
  assign in_fire = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  ndig_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_cmd(in_data.command),
    .out_free(out_free), .stat(stat), .busy(busy), .cmd(cmd)
  );

  ndig_datapath #(.MAX_DIMS(MAX_DIMS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_fire(cfg_valid), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_word(in_data), .cmd(cmd), .out_ready(out_ready),
    .stat(stat), .out_free(out_free), .out_valid(out_valid), .out_word(out_data)
  );

  a_step_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_step |=> out_valid) else $error("step gave no result");
  a_no_step_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_run |-> !in_ready) else $error("input taken during division");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data)) else $error("result changed");
endmodule

// File: bench/nd_index_checker.sv
// nd_index_checker: watches the input, result and register channels of
// nd_index_generator, predicts each result word and compares. Uses ndig_pkg.
module nd_index_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  ndig_pkg::in_word_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  ndig_pkg::out_word_t out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  output int                  errors,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [2:0]  dims_reg;
  logic [15:0] ext_reg [4];
  logic [1:0]  axis_reg;
  logic        flt_reg;
  logic [31:0] coord [4];
  logic [15:0] remaining;
  ndig_pkg::out_word_t expected_q[$];

  assign pending = expected_q.size();

  function automatic logic [31:0] single_of(input logic [31:0] v);
    int p;
    logic [31:0] mant, rem, half;
    logic [7:0] expo;
    if (v == 0) return 0;
    p = 31;
    while (!v[p]) p--;
    expo = 8'(127 + p);
    if (p <= 23) mant = v << (23 - p);
    else begin
      rem  = v & ((32'd1 << (p - 23)) - 1);
      half = 32'd1 << (p - 24);
      mant = v >> (p - 23);
      if (rem > half || (rem == half && mant[0])) begin
        mant++;
        if (mant == 32'h100_0000) begin
          mant = mant >> 1;
          expo++;
        end
      end
    end
    return {1'b0, expo, mant[22:0]};
  endfunction

  function automatic logic [31:0] extent(input int d);
    return ext_reg[d] == 0 ? 32'd1 : {16'd0, ext_reg[d]};
  endfunction

  function automatic logic [31:0] enc(input logic [31:0] v);
    return flt_reg ? single_of(v) : v;
  endfunction

  task automatic index_word(input ndig_pkg::in_word_t w);
    int n;
    logic [31:0] t;
    ndig_pkg::out_word_t e;
    logic [31:0] cs [4];
    n = dims_reg > 4 ? 4 : dims_reg;
    if (w.command == ndig_pkg::CMD_START) begin
      t = w.start_offset;
      for (int j = 0; j < 4; j++) coord[j] = 0;
      for (int j = n - 1; j >= 0; j--) begin
        coord[j] = t % extent(j);
        t = t / extent(j);
      end
      remaining = w.element_count;
      return;
    end
    if (remaining == 0) return;
    for (int j = 0; j < 4; j++) cs[j] = j < n ? enc(coord[j]) : 32'd0;
    e.selected_value = axis_reg < n ? enc(coord[axis_reg]) : 32'd0;
    e.coord_0 = cs[0];
    e.coord_1 = cs[1];
    e.coord_2 = cs[2];
    e.coord_3 = cs[3];
    e.last_of_job = remaining == 1;
    expected_q.push_back(e);
    remaining--;
    for (int d = n - 1; d >= 0; d--) begin
      coord[d]++;
      if (d == 0 || coord[d] < extent(d)) break;
      coord[d] = 0;
    end
  endtask

  task automatic cmp(input string f, input logic [31:0] x, input logic [31:0] a);
    if (x !== a) begin
      $error("%s: expected %h, got %h", f, x, a);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    ndig_pkg::out_word_t e;
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        ext_reg[i] = 16'd1;
        coord[i] = 0;
      end
      axis_reg = 0;
      flt_reg = 0;
      remaining = 0;
      errors = 0;
      expected_q.delete();
      dims_reg = 3'd1;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ndig_pkg::REG_DIMS:  dims_reg = cfg_data[2:0];
          ndig_pkg::REG_EXT0:  ext_reg[0] = cfg_data[15:0];
          ndig_pkg::REG_EXT1:  ext_reg[1] = cfg_data[15:0];
          ndig_pkg::REG_EXT2:  ext_reg[2] = cfg_data[15:0];
          ndig_pkg::REG_EXT3:  ext_reg[3] = cfg_data[15:0];
          ndig_pkg::REG_AXIS:  axis_reg = cfg_data[1:0];
          ndig_pkg::REG_FLOAT: flt_reg = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result word %h", out_data);
          errors++;
        end else begin
          e = expected_q.pop_front();
          cmp("selected_value", e.selected_value, out_data.selected_value);
          cmp("coord_0", e.coord_0, out_data.coord_0);
          cmp("coord_1", e.coord_1, out_data.coord_1);
          cmp("coord_2", e.coord_2, out_data.coord_2);
          cmp("coord_3", e.coord_3, out_data.coord_3);
          cmp("last_of_job", e.last_of_job, out_data.last_of_job);
        end
      end
      if (in_valid && in_ready) index_word(in_data);
    end
  end
endmodule

// File: bench/tb.sv
// tb: stimulus and verdict for nd_index_generator; the checker module
// nd_index_checker does prediction and comparison. Uses ndig_pkg.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, out_ready = 0, cfg_valid = 0;
  logic in_ready, out_valid, cfg_ready;
  ndig_pkg::in_word_t in_data = '0;
  ndig_pkg::out_word_t out_data;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int errors, pending;
  int cycles = 0;
  bit rx_stall_on = 1;

  nd_index_generator u_top (.*);
  nd_index_checker u_chk (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 3_000_000) begin
      $display("tb failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rx_stall_on) out_ready <= 1;
    else if ($urandom_range(0, 19) == 0) out_ready <= 0;
    else if ($urandom_range(0, 2) != 0) out_ready <= 1;
    else if (out_ready == 0 && $urandom_range(0, 9) == 0) out_ready <= 1;
    else out_ready <= $urandom_range(0, 3) != 0;
  end

  function automatic int gap_len();
    return $urandom_range(0, 9) == 0 ? $urandom_range(5, 40) : $urandom_range(0, 2);
  endfunction

  // valid stays high after acceptance unless a gap follows; drain drops it
  task automatic send_word(input logic cmd, input logic [31:0] off, input logic [15:0] cnt);
    int g;
    g = $urandom_range(0, 1) ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= '{command: cmd, start_offset: off, element_count: cnt};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic set_shape(input logic [2:0] d, input logic [15:0] e0, input logic [15:0] e1,
                           input logic [15:0] e2, input logic [15:0] e3,
                           input logic [1:0] ax, input logic fl);
    drain();
    reg_write(ndig_pkg::REG_DIMS, d);
    reg_write(ndig_pkg::REG_EXT0, e0);
    reg_write(ndig_pkg::REG_EXT1, e1);
    reg_write(ndig_pkg::REG_EXT2, e2);
    reg_write(ndig_pkg::REG_EXT3, e3);
    reg_write(ndig_pkg::REG_AXIS, ax);
    reg_write(ndig_pkg::REG_FLOAT, fl);
    cfg_valid <= 0;
  endtask

  task automatic job(input logic [31:0] off, input logic [15:0] cnt, input int steps);
    send_word(ndig_pkg::CMD_START, off, cnt);
    repeat (steps) send_word(ndig_pkg::CMD_STEP, $urandom, 16'($urandom));
  endtask

  function automatic logic [15:0] rnd_ext();
    case ($urandom_range(0, 4))
      0: return 16'($urandom_range(0, 1));
      1: return 16'hffff;
      default: return 16'($urandom_range(1, 7));
    endcase
  endfunction

  initial begin
    int sent, n;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed
    job(32'd5, 16'd3, 4);
    set_shape(3'd4, 16'd2, 16'd3, 16'd4, 16'd5, 2'd3, 1'b0);
    job(32'hffff_ffff, 16'd6, 6);
    job(32'd0, 16'd0, 2);
    set_shape(3'd7, 16'hffff, 16'hffff, 16'd0, 16'hffff, 2'd1, 1'b1);
    job(32'hffff_fffe, 16'hffff, 5);
    set_shape(3'd0, 16'd3, 16'd3, 16'd3, 16'd3, 2'd0, 1'b1);
    job(32'h1234_5678, 16'd2, 3);
    set_shape(3'd1, 16'd0, 16'd1, 16'd1, 16'd1, 2'd2, 1'b1);
    job(32'h0100_0001, 16'd3, 3);
    // random
    sent = 0;
    while (sent < 950) begin
      if ($urandom_range(0, 9) == 0) begin
        set_shape(3'($urandom_range(0, 7)), rnd_ext(), rnd_ext(), rnd_ext(), rnd_ext(),
                  2'($urandom), 1'($urandom));
        rx_stall_on = $urandom_range(0, 3) != 0;
      end
      n = $urandom_range(0, 12);
      job($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 200),
          $urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(0, 10)), n);
      sent += n + 1;
    end
    drain();
    if (errors == 0 && pending == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end
endmodule
